>>> rtl/core/adg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_pkg
// Shared constants, codes and stage bundles of the Adam gradient step unit.
// ----------------------------------------------------------------------------
package adg_pkg;

    localparam int NUM_PARAMS = 1024;
    localparam int MOM_ADDR_W = $clog2(NUM_PARAMS);

    // Pipelined restoring divider: one quotient bit per stage
    localparam int DIV_Q_W   = 63;
    localparam int DIV_NUM_W = 96;
    localparam int DIV_DEN_W = 48;

    // Square root: one root bit per stage
    localparam int SQRT_W = 32;

    // Moment read, multiply, update/write
    localparam int MOM_LAT = 3;

    localparam logic [31:0] B1_Q32        = 32'd3865470566;
    localparam logic [31:0] B2_Q32        = 32'd4252017623;
    localparam logic [28:0] A1_Q32        = 29'd429496730;
    localparam logic [25:0] A2_Q32        = 26'd42949673;
    localparam logic [47:0] EPS_Q16_32    = 48'd43;
    localparam logic [46:0] V_MAX         = {47{1'b1}};
    localparam logic [62:0] Q_CAP         = 63'h4000_0000_0000_0000;
    localparam logic [31:0] POW_ONE       = 32'hFFFF_FFFF;
    localparam logic [31:0] STEP_SIZE_RST = 32'd65536;

    typedef enum logic [1:0] {
        CFG_STEP_SIZE   = 2'd0,
        CFG_ADAM_ENABLE = 2'd1
    } cfg_reg_t;

    // Item fields carried alongside the front arithmetic
    typedef struct packed {
        logic        adam;
        logic        gneg;
        logic [31:0] gmag;
        logic [9:0]  idx;
        logic        restart;
    } front_t;

    // Item fields carried alongside the square root
    typedef struct packed {
        logic        adam;
        logic        gneg;
        logic [31:0] gmag;
        logic        vneg;
        logic [46:0] vmag;
    } mid_t;

    // Item fields carried alongside the ratio divider
    typedef struct packed {
        logic        adam;
        logic        gneg;
        logic [31:0] gmag;
        logic        vneg;
    } tail_t;

    // Control of one moment read-modify-write
    typedef struct packed {
        logic       valid;
        logic       adam;
        logic       restart;
        logic       gneg;
        logic [9:0] idx;
    } mctl_t;

endpackage

>>> rtl/core/adg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_div
// Pipelined restoring divider, one quotient bit per register stage.
// ovf flags a quotient that does not fit DIV_Q_W bits.
// ----------------------------------------------------------------------------
module adg_div (
    input  logic                          clk,
    input  logic                          adv,
    input  logic [adg_pkg::DIV_NUM_W-1:0] num,
    input  logic [adg_pkg::DIV_DEN_W-1:0] den,
    output logic [adg_pkg::DIV_Q_W-1:0]   quo,
    output logic                          ovf
);
    import adg_pkg::*;

    localparam int HI_W = DIV_NUM_W - DIV_Q_W;

    logic [DIV_DEN_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   low_reg  [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg  [DIV_Q_W];
    logic                 ovf_reg  [DIV_Q_W];

    logic [DIV_DEN_W-1:0] rem_next [DIV_Q_W];
    logic [DIV_Q_W-1:0]   low_next [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_next [DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_next [DIV_Q_W];
    logic                 ovf_next [DIV_Q_W];

    logic [DIV_DEN_W-1:0] src_rem  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   src_low  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   src_quo  [DIV_Q_W];
    logic [DIV_DEN_W:0]   shl      [DIV_Q_W];
    logic [DIV_DEN_W:0]   diff     [DIV_Q_W];

    always_comb
    begin
        for (int k = 0; k < DIV_Q_W; k++)
        begin
            if (k == 0)
            begin
                src_rem[k]  = DIV_DEN_W'(num[DIV_NUM_W-1:DIV_Q_W]);
                src_low[k]  = num[DIV_Q_W-1:0];
                src_quo[k]  = '0;
                den_next[k] = den;
                ovf_next[k] = {{(DIV_DEN_W-HI_W){1'b0}}, num[DIV_NUM_W-1:DIV_Q_W]} >= den;
            end
            else
            begin
                src_rem[k]  = rem_reg[k-1];
                src_low[k]  = low_reg[k-1];
                src_quo[k]  = quo_reg[k-1];
                den_next[k] = den_reg[k-1];
                ovf_next[k] = ovf_reg[k-1];
            end
            shl[k]      = {src_rem[k], src_low[k][DIV_Q_W-1]};
            diff[k]     = shl[k] - {1'b0, den_next[k]};
            low_next[k] = {src_low[k][DIV_Q_W-2:0], 1'b0};
            if (shl[k] >= {1'b0, den_next[k]})
            begin
                rem_next[k] = diff[k][DIV_DEN_W-1:0];
                quo_next[k] = {src_quo[k][DIV_Q_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = shl[k][DIV_DEN_W-1:0];
                quo_next[k] = {src_quo[k][DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < DIV_Q_W; k++)
            begin
                rem_reg[k] <= rem_next[k];
                low_reg[k] <= low_next[k];
                den_reg[k] <= den_next[k];
                quo_reg[k] <= quo_next[k];
                ovf_reg[k] <= ovf_next[k];
            end
        end
    end

    assign quo = quo_reg[DIV_Q_W-1];
    assign ovf = ovf_reg[DIV_Q_W-1];

endmodule

>>> rtl/core/adg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module adg_sqrt (
    input  logic                       clk,
    input  logic                       adv,
    input  logic [63:0]                x,
    output logic [adg_pkg::SQRT_W-1:0] root
);
    import adg_pkg::*;

    logic [63:0] x_reg  [SQRT_W];
    logic [63:0] r_reg  [SQRT_W];
    logic [63:0] x_next [SQRT_W];
    logic [63:0] r_next [SQRT_W];
    logic [63:0] src_x  [SQRT_W];
    logic [63:0] src_r  [SQRT_W];
    logic [63:0] bitv   [SQRT_W];
    logic [63:0] trial  [SQRT_W];

    always_comb
    begin
        for (int k = 0; k < SQRT_W; k++)
        begin
            if (k == 0)
            begin
                src_x[k] = x;
                src_r[k] = '0;
            end
            else
            begin
                src_x[k] = x_reg[k-1];
                src_r[k] = r_reg[k-1];
            end
            bitv[k]  = 64'd1 << (62 - 2 * k);
            trial[k] = src_r[k] + bitv[k];
            if (src_x[k] >= trial[k])
            begin
                x_next[k] = src_x[k] - trial[k];
                r_next[k] = (src_r[k] >> 1) + bitv[k];
            end
            else
            begin
                x_next[k] = src_x[k];
                r_next[k] = src_r[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < SQRT_W; k++)
            begin
                x_reg[k] <= x_next[k];
                r_reg[k] <= r_next[k];
            end
        end
    end

    assign root = r_reg[SQRT_W-1][SQRT_W-1:0];

endmodule

>>> rtl/core/adg_moment.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adg_moment
// Per-parameter first and second moment store with a three-stage
// read, decay-multiply, update-and-write pipeline.
// ----------------------------------------------------------------------------
module adg_moment (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  adg_pkg::mctl_t       ctl,
    input  logic [46:0]          vterm,
    input  logic [62:0]          sterm,
    output logic [47:0]          v_new,
    output logic [63:0]          s_new
);
    import adg_pkg::*;

    logic [47:0] vmem [NUM_PARAMS];
    logic [63:0] smem [NUM_PARAMS];

    // read stage
    mctl_t       b_ctl_reg;
    logic [47:0] b_vrd_reg;
    logic [63:0] b_srd_reg;
    logic [46:0] b_vterm_reg;
    logic [62:0] b_sterm_reg;

    // multiply stage
    mctl_t       c_ctl_reg;
    logic        c_vneg_reg;
    logic [46:0] c_pvhi_reg;
    logic [63:0] c_pvlo_reg;
    logic [63:0] c_pshi_reg;
    logic [63:0] c_pslo_reg;
    logic [46:0] c_vterm_reg;
    logic [62:0] c_sterm_reg;

    // result stage
    logic [47:0] d_v_reg;
    logic [63:0] d_s_reg;

    logic        b_use_old;
    logic [47:0] v_old;
    logic [63:0] s_old;
    logic [47:0] vabs48;
    logic [46:0] vabs;

    logic        c_in_range;
    logic [47:0] vdec;
    logic [63:0] sdec;
    logic signed [49:0] vdec_s;
    logic signed [49:0] vterm_s;
    logic signed [49:0] vsum;
    logic [47:0] v_next;
    logic [64:0] ssum;
    logic [63:0] s_next;

    always_comb
    begin
        b_use_old = (32'(b_ctl_reg.idx) < NUM_PARAMS) && !b_ctl_reg.restart;
        v_old     = b_use_old ? b_vrd_reg : '0;
        s_old     = b_use_old ? b_srd_reg : '0;
        vabs48    = v_old[47] ? (~v_old + 48'd1) : v_old;
        vabs      = vabs48[46:0];
    end

    always_comb
    begin
        c_in_range = 32'(c_ctl_reg.idx) < NUM_PARAMS;
        vdec       = 48'(c_pvhi_reg) + 48'(c_pvlo_reg[63:32]);
        sdec       = c_pshi_reg + 64'(c_pslo_reg[63:32]);
        vdec_s     = c_vneg_reg ? -$signed({2'b00, vdec}) : $signed({2'b00, vdec});
        vterm_s    = c_ctl_reg.gneg ? -$signed({3'b000, c_vterm_reg})
                                    : $signed({3'b000, c_vterm_reg});
        vsum       = vdec_s + vterm_s;
        if (vsum > $signed({3'b000, V_MAX}))
            v_next = {1'b0, V_MAX};
        else if (vsum < -$signed({3'b000, V_MAX}))
            v_next = ~{1'b0, V_MAX} + 48'd1;
        else
            v_next = vsum[47:0];
        ssum   = {1'b0, sdec} + 65'(c_sterm_reg);
        s_next = ssum[64] ? '1 : ssum[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vrd_reg <= vmem[ctl.idx[MOM_ADDR_W-1:0]];
            b_srd_reg <= smem[ctl.idx[MOM_ADDR_W-1:0]];
            if (c_ctl_reg.valid && c_ctl_reg.adam && c_in_range)
            begin
                vmem[c_ctl_reg.idx[MOM_ADDR_W-1:0]] <= v_next;
                smem[c_ctl_reg.idx[MOM_ADDR_W-1:0]] <= s_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_ctl_reg <= '0;
            c_ctl_reg <= '0;
        end
        else if (adv)
        begin
            b_ctl_reg <= ctl;
            c_ctl_reg <= b_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_vterm_reg <= vterm;
            b_sterm_reg <= sterm;
            c_vneg_reg  <= v_old[47];
            c_pvhi_reg  <= 47'(vabs[46:32]) * 47'(B1_Q32);
            c_pvlo_reg  <= 64'(vabs[31:0]) * 64'(B1_Q32);
            c_pshi_reg  <= 64'(s_old[63:32]) * 64'(B2_Q32);
            c_pslo_reg  <= 64'(s_old[31:0]) * 64'(B2_Q32);
            c_vterm_reg <= b_vterm_reg;
            c_sterm_reg <= b_sterm_reg;
            d_v_reg     <= v_next;
            d_s_reg     <= s_next;
        end
    end

    assign v_new = d_v_reg;
    assign s_new = d_s_reg;

endmodule

>>> rtl/core/adam_gradient_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adam_gradient_step
// Adam optimizer step unit: one signed Q16.16 gradient in, one saturated
// Q16.16 parameter change out, with per-parameter moments kept in RAM.
//
//   channel  handshake              payload
//   in       in_valid / in_stall    param_index, gradient, pass_start, restart
//   out      out_valid / out_stall  step, saturated
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle while in_stall is low; the path runs through the two
// 63-stage dividers in series, the 32-stage square root and the three-stage moment
// update. In Adam mode an item whose index matches a valid item in stage s1 or s2
// waits until that item has moved on: the moment read-modify-write spans three
// stages. Stall from the output freezes the whole pipeline.
// Reset restores the registers and powers; the moment RAM is not cleared.
// ----------------------------------------------------------------------------
module adam_gradient_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  param_index,
    input  logic signed [31:0] gradient,
    input  logic        pass_start,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [31:0] step,
    output logic        saturated,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import adg_pkg::*;

    logic [31:0] step_size_reg;
    logic        adam_reg;
    logic [31:0] pow1_reg;
    logic [31:0] pow2_reg;
    logic [31:0] pow1_next;
    logic [31:0] pow2_next;
    logic [63:0] pow1_prod;
    logic [63:0] pow2_prod;

    logic        adv;
    logic        hazard;
    logic        accept;
    logic [31:0] gmag;
    front_t      in_front;

    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    front_t      s1_front_reg, s2_front_reg, s3_front_reg, s4_front_reg;
    logic [31:0] s1_p1_reg, s1_p2_reg;
    logic [60:0] s2_va_reg, s3_va_reg, s4_va_reg;
    logic [63:0] s2_gsq_reg;
    logic [32:0] s2_c1_reg, s3_c1_reg, s4_c1_reg;
    logic [32:0] s2_c2_reg, s3_c2_reg, s4_c2_reg;
    logic [57:0] s3_thi_reg, s3_tlo_reg, s4_t_reg;

    logic        fd_valid_reg [DIV_Q_W];
    front_t      fd_reg       [DIV_Q_W];
    logic [DIV_Q_W-1:0] dv_quo, ds_quo;
    logic        dv_ovf, ds_ovf;
    logic [46:0] vterm;
    logic [62:0] sterm;
    mctl_t       mctl;

    logic        md_valid_reg [MOM_LAT];
    front_t      md_reg       [MOM_LAT];
    logic [47:0] v_new;
    logic [63:0] s_new;
    logic [47:0] vabs48;
    mid_t        mid_in;

    logic        sq_valid_reg [SQRT_W];
    mid_t        sq_reg       [SQRT_W];
    logic [SQRT_W-1:0] root;
    tail_t       tail_in;

    logic        rd_valid_reg [DIV_Q_W];
    tail_t       rd_reg       [DIV_Q_W];
    logic [DIV_Q_W-1:0] rv_quo;
    logic        rv_ovf;
    logic [62:0] ratio;

    logic        f_valid_reg;
    logic        f_big_reg;
    logic        f_neg_reg;
    logic [63:0] f_prod_reg;
    logic [31:0] oper;

    logic        out_valid_reg;
    logic [31:0] step_reg;
    logic        sat_reg;
    logic [47:0] mag;
    logic [47:0] limit;
    logic        sat_next;
    logic [31:0] magc;
    logic [31:0] step_next;

    // ---------------- input, configuration and powers ----------------
    assign cfg_ready = 1'b1;
    assign adv       = !out_valid_reg || !out_stall;
    assign hazard    = adam_reg &&
                       ((s1_valid_reg && s1_front_reg.idx == param_index) ||
                        (s2_valid_reg && s2_front_reg.idx == param_index));
    assign in_stall  = !adv || hazard;
    assign accept    = in_valid && !in_stall;

    always_comb
    begin
        gmag      = gradient[31] ? (~gradient + 32'd1) : gradient;
        pow1_prod = 64'(pow1_reg) * 64'(B1_Q32);
        pow2_prod = 64'(pow2_reg) * 64'(B2_Q32);
        pow1_next = pow1_reg;
        pow2_next = pow2_reg;
        if (pass_start)
        begin
            pow1_next = restart ? B1_Q32 : pow1_prod[63:32];
            pow2_next = restart ? B2_Q32 : pow2_prod[63:32];
        end
        in_front.adam    = adam_reg;
        in_front.gneg    = gradient[31];
        in_front.gmag    = gmag;
        in_front.idx     = param_index;
        in_front.restart = restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= STEP_SIZE_RST;
            adam_reg      <= 1'b1;
            pow1_reg      <= POW_ONE;
            pow2_reg      <= POW_ONE;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_STEP_SIZE:   step_size_reg <= cfg_data;
                    CFG_ADAM_ENABLE: adam_reg      <= cfg_data[0];
                    default:         ;
                endcase
            end
            if (accept)
            begin
                pow1_reg <= pow1_next;
                pow2_reg <= pow2_next;
            end
        end
    end

    // ---------------- front stages: products and term numerators ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_front_reg <= in_front;
            s1_p1_reg    <= pow1_next;
            s1_p2_reg    <= pow2_next;

            s2_front_reg <= s1_front_reg;
            s2_va_reg    <= 61'(s1_front_reg.gmag) * 61'(A1_Q32);
            s2_gsq_reg   <= 64'(s1_front_reg.gmag) * 64'(s1_front_reg.gmag);
            s2_c1_reg    <= 33'h1_0000_0000 - 33'(s1_p1_reg);
            s2_c2_reg    <= 33'h1_0000_0000 - 33'(s1_p2_reg);

            s3_front_reg <= s2_front_reg;
            s3_va_reg    <= s2_va_reg;
            s3_thi_reg   <= 58'(s2_gsq_reg[63:32]) * 58'(A2_Q32);
            s3_tlo_reg   <= 58'(s2_gsq_reg[31:0]) * 58'(A2_Q32);
            s3_c1_reg    <= s2_c1_reg;
            s3_c2_reg    <= s2_c2_reg;

            s4_front_reg <= s3_front_reg;
            s4_va_reg    <= s3_va_reg;
            s4_t_reg     <= s3_thi_reg + 58'(s3_tlo_reg[57:32]);
            s4_c1_reg    <= s3_c1_reg;
            s4_c2_reg    <= s3_c2_reg;
        end
    end

    // ---------------- bias-corrected gradient terms ----------------
    adg_div u_div_v (
        .clk (clk),
        .adv (adv),
        .num ({35'd0, s4_va_reg}),
        .den ({15'd0, s4_c1_reg}),
        .quo (dv_quo),
        .ovf (dv_ovf)
    );

    adg_div u_div_s (
        .clk (clk),
        .adv (adv),
        .num ({6'd0, s4_t_reg, 32'd0}),
        .den ({15'd0, s4_c2_reg}),
        .quo (ds_quo),
        .ovf (ds_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_Q_W; k++)
                fd_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            fd_valid_reg[0] <= s4_valid_reg;
            for (int k = 1; k < DIV_Q_W; k++)
                fd_valid_reg[k] <= fd_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fd_reg[0] <= s4_front_reg;
            for (int k = 1; k < DIV_Q_W; k++)
                fd_reg[k] <= fd_reg[k-1];
        end
    end

    always_comb
    begin
        vterm = (dv_ovf || dv_quo > DIV_Q_W'(V_MAX)) ? V_MAX : dv_quo[46:0];
        sterm = (ds_ovf || ds_quo > Q_CAP) ? Q_CAP : ds_quo;
        mctl.valid   = fd_valid_reg[DIV_Q_W-1];
        mctl.adam    = fd_reg[DIV_Q_W-1].adam;
        mctl.restart = fd_reg[DIV_Q_W-1].restart;
        mctl.gneg    = fd_reg[DIV_Q_W-1].gneg;
        mctl.idx     = fd_reg[DIV_Q_W-1].idx;
    end

    // ---------------- moment update ----------------
    adg_moment u_moment (
        .clk   (clk),
        .rst_n (rst_n),
        .adv   (adv),
        .ctl   (mctl),
        .vterm (vterm),
        .sterm (sterm),
        .v_new (v_new),
        .s_new (s_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MOM_LAT; k++)
                md_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            md_valid_reg[0] <= fd_valid_reg[DIV_Q_W-1];
            for (int k = 1; k < MOM_LAT; k++)
                md_valid_reg[k] <= md_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            md_reg[0] <= fd_reg[DIV_Q_W-1];
            for (int k = 1; k < MOM_LAT; k++)
                md_reg[k] <= md_reg[k-1];
        end
    end

    always_comb
    begin
        vabs48      = v_new[47] ? (~v_new + 48'd1) : v_new;
        mid_in.adam = md_reg[MOM_LAT-1].adam;
        mid_in.gneg = md_reg[MOM_LAT-1].gneg;
        mid_in.gmag = md_reg[MOM_LAT-1].gmag;
        mid_in.vneg = v_new[47];
        mid_in.vmag = vabs48[46:0];
    end

    // ---------------- root of the second moment ----------------
    adg_sqrt u_sqrt (
        .clk  (clk),
        .adv  (adv),
        .x    (s_new),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SQRT_W; k++)
                sq_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= md_valid_reg[MOM_LAT-1];
            for (int k = 1; k < SQRT_W; k++)
                sq_valid_reg[k] <= sq_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg[0] <= mid_in;
            for (int k = 1; k < SQRT_W; k++)
                sq_reg[k] <= sq_reg[k-1];
        end
    end

    always_comb
    begin
        tail_in.adam = sq_reg[SQRT_W-1].adam;
        tail_in.gneg = sq_reg[SQRT_W-1].gneg;
        tail_in.gmag = sq_reg[SQRT_W-1].gmag;
        tail_in.vneg = sq_reg[SQRT_W-1].vneg;
    end

    // ---------------- moment ratio ----------------
    adg_div u_div_r (
        .clk (clk),
        .adv (adv),
        .num ({17'd0, sq_reg[SQRT_W-1].vmag, 32'd0}),
        .den ({root, 16'd0} + EPS_Q16_32),
        .quo (rv_quo),
        .ovf (rv_ovf)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_Q_W; k++)
                rd_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            rd_valid_reg[0] <= sq_valid_reg[SQRT_W-1];
            for (int k = 1; k < DIV_Q_W; k++)
                rd_valid_reg[k] <= rd_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_reg[0] <= tail_in;
            for (int k = 1; k < DIV_Q_W; k++)
                rd_reg[k] <= rd_reg[k-1];
        end
    end

    // ---------------- scale by step size, saturate ----------------
    always_comb
    begin
        ratio = (rv_ovf || rv_quo > Q_CAP) ? Q_CAP : rv_quo;
        oper  = rd_reg[DIV_Q_W-1].adam ? ratio[31:0] : rd_reg[DIV_Q_W-1].gmag;
    end

    always_comb
    begin
        mag       = f_big_reg ? '1 : f_prod_reg[63:16];
        limit     = f_neg_reg ? 48'h0000_8000_0000 : 48'h0000_7FFF_FFFF;
        sat_next  = mag > limit;
        magc      = sat_next ? limit[31:0] : mag[31:0];
        step_next = f_neg_reg ? (~magc + 32'd1) : magc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg   <= rd_valid_reg[DIV_Q_W-1];
            out_valid_reg <= f_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_big_reg  <= rd_reg[DIV_Q_W-1].adam && (ratio[62:32] != '0) &&
                          (step_size_reg != '0);
            f_neg_reg  <= rd_reg[DIV_Q_W-1].adam ? rd_reg[DIV_Q_W-1].vneg
                                                 : rd_reg[DIV_Q_W-1].gneg;
            f_prod_reg <= 64'(oper) * 64'(step_size_reg);
            step_reg   <= step_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign step      = step_reg;
    assign saturated = sat_reg;

    // ---------------- assertions ----------------
    a_rmw_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s1_front_reg.adam && s2_front_reg.adam)
        |-> (s1_front_reg.idx != s2_front_reg.idx))
        else $error("two Adam items with one index closer than the moment update");

    a_stall_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |-> in_stall)
        else $error("input taken while the pipeline is frozen");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (step == 32'sh7FFF_FFFF || step == 32'sh8000_0000))
        else $error("saturated flag without a clipped step");

endmodule

>>> sim/tb_adam_gradient_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_adam_gradient_step
// Self-checking bench for the Adam gradient step unit. A driver streams
// gradient items from a queue and a monitor checks every step, field by
// field, against a bit-accurate predictor of the moments, bias-corrected
// powers and saturation. Both sides idle and stall at random, and the run
// goes through several learning-rate and mode settings, the extremes among
// them.
// ----------------------------------------------------------------------------
module tb_adam_gradient_step;
    import adg_pkg::*;

    localparam longint unsigned M32     = 64'hFFFF_FFFF;
    localparam longint unsigned BETA1   = 64'd3865470566;
    localparam longint unsigned BETA2   = 64'd4252017623;
    localparam longint unsigned ALPHA1  = 64'd429496730;
    localparam longint unsigned ALPHA2  = 64'd42949673;
    localparam longint unsigned EPSILON = 64'd43;
    localparam longint          VCAP    = 64'h7FFF_FFFF_FFFF;
    localparam longint unsigned QCAP    = 64'h4000_0000_0000_0000;
    localparam int              LAT     = 200;
    localparam int              CYCLE_LIMIT = 400000;

    typedef struct {
        logic [9:0]  idx;
        logic [31:0] grad;
        logic        ps;
        logic        rs;
    } grad_item_t;

    typedef struct {
        logic [31:0] step;
        logic        sat;
    } step_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [9:0]  param_index;
    logic signed [31:0] gradient;
    logic        pass_start;
    logic        restart;
    logic        out_valid;
    logic        out_stall;
    logic signed [31:0] step;
    logic        saturated;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    adam_gradient_step i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .param_index(param_index),
        .gradient   (gradient),
        .pass_start (pass_start),
        .restart    (restart),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .step       (step),
        .saturated  (saturated),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // predictor state
    longint          mom1 [NUM_PARAMS];
    longint unsigned mom2 [NUM_PARAMS];
    longint unsigned pow1;
    longint unsigned pow2;
    longint unsigned lr;
    logic            adam_on;

    // generator view: which moments hold data, and the mode being generated for
    bit              written [NUM_PARAMS];
    logic            gen_adam;

    grad_item_t  pending_items[$];
    step_res_t   expected_steps[$];
    int          errors;
    int          cycles;
    int          gap_left;
    int          stall_left;
    bit          in_taken;
    bit          out_taken;
    bit          burst;

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic longint unsigned mul_frac(longint unsigned m, longint unsigned b);
        return (m >> 32) * b + (((m & M32) * b) >> 32);
    endfunction

    function automatic longint unsigned div_frac(longint unsigned num, longint unsigned den,
                                                 int sh, longint unsigned cap);
        longint unsigned q;
        longint unsigned r;
        q = num / den;
        r = num % den;
        if (q > (cap >> sh))
            return cap;
        for (int i = 0; i < sh; i++)
        begin
            q = q << 1;
            r = r << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 64'd1;
            end
        end
        return (q > cap) ? cap : q;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic step_res_t predict_step(grad_item_t it);
        step_res_t       res;
        logic            neg;
        longint unsigned gmag;
        longint unsigned mag;
        longint unsigned lim;
        longint          v_old;
        longint          v_new;
        longint unsigned s_old;
        longint unsigned vterm;
        longint unsigned vdec;
        longint unsigned sterm;
        longint unsigned s_new;
        longint unsigned den;
        longint unsigned vmag;
        longint unsigned ratio;
        neg  = it.grad[31];
        gmag = neg ? ((64'd1 << 32) - {32'd0, it.grad}) : {32'd0, it.grad};
        res.sat = 1'b0;
        if (it.ps)
        begin
            pow1 = it.rs ? BETA1 : mul_frac(pow1, BETA1);
            pow2 = it.rs ? BETA2 : mul_frac(pow2, BETA2);
        end
        if (adam_on)
        begin
            v_old = it.rs ? 0 : mom1[it.idx];
            s_old = it.rs ? 0 : mom2[it.idx];
            vterm = (gmag * ALPHA1) / ((64'd1 << 32) - pow1);
            if (vterm > VCAP)
                vterm = VCAP;
            vdec = mul_frac((v_old < 0) ? -v_old : v_old, BETA1);
            v_new = ((v_old < 0) ? -longint'(vdec) : longint'(vdec))
                    + (neg ? -longint'(vterm) : longint'(vterm));
            if (v_new > VCAP)
                v_new = VCAP;
            if (v_new < -VCAP)
                v_new = -VCAP;
            sterm = div_frac(mul_frac(gmag * gmag, ALPHA2), (64'd1 << 32) - pow2, 32, QCAP);
            s_new = mul_frac(s_old, BETA2) + sterm;
            if (s_new < sterm)
                s_new = ~64'd0;
            mom1[it.idx] = v_new;
            mom2[it.idx] = s_new;
            den = (int_sqrt(s_new) << 16) + EPSILON;
            neg = v_new < 0;
            vmag = neg ? -v_new : v_new;
            ratio = div_frac(vmag, den, 32, QCAP);
            if ((ratio >> 32) != 0 && lr != 0)
                mag = ~64'd0;
            else
                mag = ((ratio & M32) * lr) >> 16;
        end
        else
            mag = (gmag * lr) >> 16;
        lim = neg ? (64'd1 << 31) : ((64'd1 << 31) - 1);
        if (mag > lim)
        begin
            mag = lim;
            res.sat = 1'b1;
        end
        res.step = neg ? 32'((64'd1 << 32) - mag) : mag[31:0];
        return res;
    endfunction

    function automatic logic [31:0] pick_gradient();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return -{14'd0, 18'($urandom_range(0, 262143))};
            3: return {14'd0, 18'($urandom_range(0, 262143))};
            default: return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    // Queue one item; force a restart where a moment would be read unwritten
    task automatic queue_item(logic [9:0] idx, logic [31:0] g, logic ps, logic rs);
        grad_item_t it;
        if (gen_adam && !written[idx])
            rs = 1'b1;
        if (gen_adam)
            written[idx] = 1'b1;
        it.idx = idx;
        it.grad = g;
        it.ps = ps;
        it.rs = rs;
        pending_items = {pending_items, it};
    endtask

    task automatic write_reg(cfg_reg_t r, logic [31:0] d);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic set_mode(logic [31:0] rate, logic adam);
        write_reg(CFG_STEP_SIZE, rate);
        write_reg(CFG_ADAM_ENABLE, {31'd0, adam});
        gen_adam = adam;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || expected_steps.size() > 0)
            @(posedge clk);
        repeat (LAT) @(posedge clk);
    endtask

    // Iterations over a small working set, with some noise items mixed in
    task automatic queue_iterations(int n_items);
        int         count;
        int         base;
        int         width;
        int         reps;
        bit         first;
        logic [9:0] idx;
        count = 0;
        first = 1'b1;
        while (count < n_items)
        begin
            base = $urandom_range(0, 1023);
            width = $urandom_range(1, 12);
            reps = $urandom_range(1, 4);
            for (int k = 0; k < width * reps; k++)
            begin
                idx = 10'(base + (k % width));
                if ($urandom_range(0, 9) == 0)
                    queue_item(10'($urandom), pick_gradient(), 1'($urandom), 1'($urandom));
                else
                    queue_item(idx, pick_gradient(), k == 0, first && (k < width));
                count++;
            end
            first = ($urandom_range(0, 5) == 0);
        end
    endtask

    // driver
    always @(negedge clk)
    begin
        grad_item_t it;
        if (rst_n)
        begin
            if (in_valid && !in_taken)
            begin
                // hold the stalled transaction
            end
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_items.size() > 0)
            begin
                it = pending_items.pop_front();
                in_valid <= 1'b1;
                param_index <= it.idx;
                gradient <= it.grad;
                pass_start <= it.ps;
                restart <= it.rs;
                gap_left <= burst ? 0 : $urandom_range(0, 4);
                if ($urandom_range(0, 63) == 0)
                    burst <= ~burst;
            end
            else
                in_valid <= 1'b0;

            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall <= 1'b0;
                if (out_taken)
                    stall_left <= burst ? 0 : $urandom_range(0, 4);
            end
        end
    end

    // monitor and checker
    always @(posedge clk)
    begin
        grad_item_t it;
        step_res_t  exp_r;
        cycles <= cycles + 1;
        in_taken <= in_valid && !in_stall;
        out_taken <= out_valid && !out_stall;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_STEP_SIZE)
                    lr = cfg_data;
                else if (cfg_index == CFG_ADAM_ENABLE)
                    adam_on = cfg_data[0];
            end
            if (in_valid && !in_stall)
            begin
                it.idx = param_index;
                it.grad = gradient;
                it.ps = pass_start;
                it.rs = restart;
                expected_steps = {expected_steps, predict_step(it)};
            end
            if (out_valid && !out_stall)
            begin
                if (expected_steps.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("ERROR: unexpected step %h sat %b", step, saturated);
                end
                else
                begin
                    exp_r = expected_steps.pop_front();
                    if (step !== exp_r.step || saturated !== exp_r.sat)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("ERROR: step exp %h/%b got %h/%b",
                                     exp_r.step, exp_r.sat, step, saturated);
                    end
                end
            end
        end
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        logic [31:0] rate;
        in_valid = 1'b0;
        param_index = '0;
        gradient = '0;
        pass_start = 1'b0;
        restart = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_STEP_SIZE;
        cfg_data = '0;
        errors = 0;
        cycles = 0;
        gap_left = 0;
        stall_left = 0;
        in_taken = 1'b0;
        out_taken = 1'b0;
        burst = 1'b0;
        pow1 = M32;
        pow2 = M32;
        lr = STEP_SIZE_RST;
        adam_on = 1'b1;
        gen_adam = 1'b1;
        for (int i = 0; i < NUM_PARAMS; i++)
        begin
            mom1[i] = 0;
            mom2[i] = 0;
            written[i] = 1'b0;
        end
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset settings, extremes, power advance and restarts
        queue_item(10'd0, 32'd0, 1'b1, 1'b1);
        queue_item(10'd1023, 32'h7FFF_FFFF, 1'b0, 1'b1);
        queue_item(10'd5, 32'h8000_0000, 1'b0, 1'b1);
        queue_item(10'd0, 32'd1, 1'b0, 1'b0);
        queue_item(10'd0, 32'hFFFF_FFFF, 1'b0, 1'b0);
        queue_item(10'd5, 32'h0001_0000, 1'b1, 1'b0);
        queue_item(10'd1023, 32'h8000_0000, 1'b0, 1'b0);
        queue_item(10'd5, 32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_item(10'd0, 32'hFFFF_0000, 1'b0, 1'b1);
        queue_item(10'd1023, 32'h0000_8000, 1'b1, 1'b1);
        drain();
        set_mode(32'hFFFF_FFFF, 1'b1);
        queue_item(10'd0, 32'h0001_0000, 1'b1, 1'b0);
        queue_item(10'd5, 32'h8000_0000, 1'b0, 1'b0);
        queue_item(10'd0, 32'd3, 1'b0, 1'b0);
        drain();
        set_mode(32'd0, 1'b1);
        queue_item(10'd0, 32'h7FFF_FFFF, 1'b1, 1'b1);
        queue_item(10'd1023, 32'h8000_0000, 1'b0, 1'b0);
        drain();
        set_mode(32'hFFFF_FFFF, 1'b0);
        queue_item(10'd7, 32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_item(10'd7, 32'h8000_0000, 1'b1, 1'b0);
        queue_item(10'd9, 32'd1, 1'b0, 1'b1);
        queue_item(10'd9, 32'hFFFF_FFFF, 1'b0, 1'b0);
        drain();
        // register beyond the list: ignored
        write_reg(cfg_reg_t'(2'd3), 32'hA5A5_5A5A);
        set_mode(32'd65536, 1'b0);
        queue_item(10'd0, 32'h8000_0000, 1'b0, 1'b0);
        queue_item(10'd0, 32'h7FFF_FFFF, 1'b0, 1'b0);
        drain();

        // random phases
        for (int p = 0; p < 8; p++)
        begin
            case ($urandom_range(0, 3))
                0: rate = $urandom;
                1: rate = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
                default: rate = $urandom_range(1 << 12, 1 << 18);
            endcase
            set_mode(rate, ($urandom_range(0, 3) != 0));
            queue_iterations(250);
            drain();
        end

        if (errors == 0 && expected_steps.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/adg_pkg.sv
rtl/core/adg_div.sv
rtl/core/adg_sqrt.sv
rtl/core/adg_moment.sv
rtl/core/adam_gradient_step.sv
sim/tb_adam_gradient_step.sv
